// ----- rtl/core/fbd_pkg.sv -----
// Shared types and constants of the framebuffer drawing engine.
package fbd_pkg;

    // Width of one input coordinate or radius.
    localparam int COORD_W = 10;
    // Signed width of a plotted coordinate before clipping.
    localparam int SCW = 12;
    // Width of a squared radius.
    localparam int RAD2_W = 2 * COORD_W;
    // Width of the square root remainder.
    localparam int SQ_REM_W = COORD_W + 2;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_POINT  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_CIRCLE = 3'd3,
        MODE_READ   = 3'd4
    } fbd_mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POINT,
        ST_LINE_SETUP,
        ST_LINE,
        ST_CIR_SETUP,
        ST_CIR_CHECK,
        ST_CIR_SQRT,
        ST_CIR_PLOT,
        ST_RD_ADDR,
        ST_RD_OUT
    } fbd_state_t;

    // Status of the square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } fbd_sqrt_stat_t;

endpackage

// ----- rtl/core/fbd_ram.sv -----
// Generic single write port RAM with one registered read port.
module fbd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fbd_sqrt.sv -----
// Digit-recurrence integer square root, two radicand bits per cycle.
module fbd_sqrt (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [fbd_pkg::RAD2_W-1:0]            radicand,
    output logic [fbd_pkg::COORD_W-1:0]           root,
    output logic [fbd_pkg::SQ_REM_W-1:0]          remainder,
    output fbd_pkg::fbd_sqrt_stat_t               stat
);
    import fbd_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COORD_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [RAD2_W-1:0]     v_reg, v_next;
    logic [SQ_REM_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]    root_reg, root_next;
    logic [SQ_REM_W+1:0]   rem_sh;
    logic [SQ_REM_W+1:0]   trial;

    // One result bit per cycle: shift in two radicand bits and try to subtract.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg, v_reg[RAD2_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            v_next = {v_reg[RAD2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = SQ_REM_W'(rem_sh - trial);
                root_next = {root_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = SQ_REM_W'(rem_sh);
                root_next = {root_reg[COORD_W-2:0], 1'b0};
            end
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/core/framebuffer_line_circle_drawer_unit.sv -----
// Framebuffer drawing engine: top level with command sequencer and pixel store.
//
// One command beat is taken at a time. The clearing pass after reset writes
// one pixel a cycle over all FRAME_HEIGHT*FRAME_WIDTH addresses, and a clear
// command runs the same pass. A point writes one pixel, an unused mode does
// nothing, and a read returns the pixel once the result stall lets it. A line
// writes one pixel a cycle over max(|drow|,|dcol|)+1 pixels, the rounded
// coordinates tracked by a quotient and remainder pair per axis. A circle
// steps y from 0 to the octant end; for each y it starts the square root
// unit, waits while it runs, and then plots the eight mirrored points, which
// go one a cycle through the single pixel write port.
module framebuffer_line_circle_drawer_unit #(
    parameter int FRAME_HEIGHT = 64,
    parameter int FRAME_WIDTH  = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    mode,
    input  logic [fbd_pkg::COORD_W-1:0]   row_a,
    input  logic [fbd_pkg::COORD_W-1:0]   col_a,
    input  logic [fbd_pkg::COORD_W-1:0]   row_b,
    input  logic [fbd_pkg::COORD_W-1:0]   col_b,
    input  logic [fbd_pkg::COORD_W-1:0]   radius,
    input  logic                          color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pixel_value
);
    import fbd_pkg::*;

    localparam int DEPTH  = FRAME_HEIGHT * FRAME_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic signed [SCW-1:0] HEIGHT_S  = SCW'(FRAME_HEIGHT);
    localparam logic signed [SCW-1:0] WIDTH_S   = SCW'(FRAME_WIDTH);
    localparam logic [RAD2_W-1:0]     WIDTH_M   = RAD2_W'(FRAME_WIDTH);
    localparam int REM_W = SCW + 1;

    fbd_state_t state_reg, state_next;

    // Command registers.
    logic [COORD_W-1:0]      ra_reg, ra_next, ca_reg, ca_next;
    logic [COORD_W-1:0]      rb_reg, rb_next, cb_reg, cb_next;
    logic [COORD_W-1:0]      rad_reg, rad_next;
    logic                    color_reg, color_next;

    // Clear sweep.
    logic [ADDR_W-1:0]       clr_reg, clr_next;

    // Line stepping.
    logic [COORD_W-1:0]      tot_reg, tot_next, step_reg, step_next;
    logic [COORD_W:0]        t2_reg, t2_next;
    logic signed [SCW-1:0]   d2r_reg, d2r_next, d2c_reg, d2c_next;
    logic signed [SCW-1:0]   qr_reg, qr_next, qc_reg, qc_next;
    logic signed [REM_W-1:0] remr_reg, remr_next, remc_reg, remc_next;

    // Circle stepping.
    logic [RAD2_W-1:0]       rad2_reg, rad2_next;
    logic [COORD_W-1:0]      x_reg, x_next;
    logic [COORD_W:0]        y_reg, y_next;
    logic [RAD2_W:0]         ysq_reg, ysq_next;
    logic [2:0]              ph_reg, ph_next;

    // Result channel.
    logic                    out_valid_reg, out_valid_next;
    logic                    pix_reg, pix_next;

    // Pixel port.
    logic signed [SCW-1:0]   p_row, p_col;
    logic                    p_we, p_data, p_in_frame;
    logic [RAD2_W:0]         p_lin;
    logic [ADDR_W-1:0]       p_addr;
    logic                    ram_we, ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]       ram_waddr;

    // Square root unit.
    logic                    sq_start;
    logic [RAD2_W-1:0]       sq_v;
    logic [COORD_W-1:0]      sq_root;
    logic [SQ_REM_W-1:0]     sq_rem;
    fbd_sqrt_stat_t          sq_stat;

    // Line setup values.
    logic signed [SCW-1:0]   dr, dc, adr, adc;
    logic [COORD_W-1:0]      tot_c;

    // Circle coordinates.
    logic signed [SCW-1:0]   c_row, c_col, c_x, c_y;

    // One step of a rounded coordinate: add twice the delta, fix by one divisor.
    function automatic logic [SCW+REM_W-1:0] lerp_step(
        input logic signed [SCW-1:0]   q,
        input logic signed [REM_W-1:0] rem,
        input logic signed [SCW-1:0]   d2,
        input logic [COORD_W:0]        t2
    );
        logic signed [REM_W-1:0] nr;
        logic signed [REM_W-1:0] t2s;
        logic signed [SCW-1:0]   nq;
        t2s = $signed({2'b00, t2});
        nr  = rem + $signed({d2[SCW-1], d2});
        nq  = q;
        if (nr >= t2s)
        begin
            nr = nr - t2s;
            nq = q + SCW'(1);
        end
        else if (nr < 0)
        begin
            nr = nr + t2s;
            nq = q - SCW'(1);
        end
        return {nq, nr};
    endfunction

    assign dr    = $signed({2'b00, rb_reg}) - $signed({2'b00, ra_reg});
    assign dc    = $signed({2'b00, cb_reg}) - $signed({2'b00, ca_reg});
    assign adr   = (dr < 0) ? -dr : dr;
    assign adc   = (dc < 0) ? -dc : dc;
    assign tot_c = (adr > adc) ? COORD_W'(adr) : COORD_W'(adc);

    assign c_row = $signed({2'b00, ra_reg});
    assign c_col = $signed({2'b00, ca_reg});
    assign c_x   = $signed({2'b00, x_reg});
    assign c_y   = $signed({1'b0, y_reg});

    // Sequencer: next state, datapath updates and pixel port selection.
    always_comb
    begin
        state_next     = state_reg;
        ra_next        = ra_reg;
        ca_next        = ca_reg;
        rb_next        = rb_reg;
        cb_next        = cb_reg;
        rad_next       = rad_reg;
        color_next     = color_reg;
        clr_next       = clr_reg;
        tot_next       = tot_reg;
        step_next      = step_reg;
        t2_next        = t2_reg;
        d2r_next       = d2r_reg;
        d2c_next       = d2c_reg;
        qr_next        = qr_reg;
        qc_next        = qc_reg;
        remr_next      = remr_reg;
        remc_next      = remc_reg;
        rad2_next      = rad2_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ysq_next       = ysq_reg;
        ph_next        = ph_reg;
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        p_row          = c_row;
        p_col          = c_col;
        p_we           = 1'b0;
        p_data         = 1'b1;
        sq_start       = 1'b0;
        sq_v           = RAD2_W'(rad2_reg - ysq_reg[RAD2_W-1:0]);
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ra_next    = row_a;
                    ca_next    = col_a;
                    rb_next    = row_b;
                    cb_next    = col_b;
                    rad_next   = radius;
                    color_next = color;
                    case (mode)
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        MODE_POINT:  state_next = ST_POINT;
                        MODE_LINE:   state_next = ST_LINE_SETUP;
                        MODE_CIRCLE: state_next = ST_CIR_SETUP;
                        MODE_READ:   state_next = ST_RD_ADDR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POINT:
            begin
                p_we       = 1'b1;
                p_data     = color_reg;
                state_next = ST_IDLE;
            end
            ST_LINE_SETUP:
            begin
                tot_next   = tot_c;
                t2_next    = {tot_c, 1'b0};
                d2r_next   = dr <<< 1;
                d2c_next   = dc <<< 1;
                qr_next    = c_row;
                qc_next    = c_col;
                remr_next  = $signed({3'b000, tot_c});
                remc_next  = $signed({3'b000, tot_c});
                step_next  = '0;
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                p_row = qr_reg;
                p_col = qc_reg;
                p_we  = 1'b1;
                if (step_reg == tot_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next            = step_reg + 1'b1;
                    {qr_next, remr_next} = lerp_step(qr_reg, remr_reg, d2r_reg, t2_reg);
                    {qc_next, remc_next} = lerp_step(qc_reg, remc_reg, d2c_reg, t2_reg);
                end
            end
            ST_CIR_SETUP:
            begin
                rad2_next  = {{COORD_W{1'b0}}, rad_reg} * {{COORD_W{1'b0}}, rad_reg};
                x_next     = rad_reg;
                y_next     = '0;
                ysq_next   = '0;
                state_next = ST_CIR_CHECK;
            end
            ST_CIR_CHECK:
            begin
                if (y_reg > {1'b0, x_reg})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = ST_CIR_SQRT;
                end
            end
            ST_CIR_SQRT:
            begin
                if (sq_stat.done)
                begin
                    // Round half up: one more when the remainder exceeds the root.
                    if (sq_rem > {2'b00, sq_root})
                    begin
                        x_next = sq_root + 1'b1;
                    end
                    else
                    begin
                        x_next = sq_root;
                    end
                    ph_next    = '0;
                    state_next = ST_CIR_PLOT;
                end
            end
            ST_CIR_PLOT:
            begin
                p_we = 1'b1;
                case (ph_reg)
                    3'd0:    begin p_row = c_row + c_y; p_col = c_col + c_x; end
                    3'd1:    begin p_row = c_row - c_y; p_col = c_col + c_x; end
                    3'd2:    begin p_row = c_row + c_y; p_col = c_col - c_x; end
                    3'd3:    begin p_row = c_row - c_y; p_col = c_col - c_x; end
                    3'd4:    begin p_row = c_row + c_x; p_col = c_col + c_y; end
                    3'd5:    begin p_row = c_row - c_x; p_col = c_col + c_y; end
                    3'd6:    begin p_row = c_row + c_x; p_col = c_col - c_y; end
                    default: begin p_row = c_row - c_x; p_col = c_col - c_y; end
                endcase
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd7)
                begin
                    y_next     = y_reg + 1'b1;
                    ysq_next   = ysq_reg + (RAD2_W + 1)'({y_reg, 1'b1});
                    state_next = ST_CIR_CHECK;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pix_next       = p_in_frame & ram_rdata;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Clip and linear address of the selected pixel.
    assign p_in_frame = (p_row >= 0) && (p_row < HEIGHT_S) && (p_col >= 0) && (p_col < WIDTH_S);
    assign p_lin      = (RAD2_W + 1)'({{(RAD2_W - COORD_W){1'b0}}, p_row[COORD_W-1:0]} * WIDTH_M)
                      + (RAD2_W + 1)'(p_col[COORD_W-1:0]);
    assign p_addr     = p_lin[ADDR_W-1:0];

    assign ram_we    = (state_reg == ST_CLEAR) || (p_we && p_in_frame);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : p_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 1'b0 : p_data;

    fbd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (p_addr),
        .rdata (ram_rdata)
    );

    fbd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sq_start),
        .radicand  (sq_v),
        .root      (sq_root),
        .remainder (sq_rem),
        .stat      (sq_stat)
    );

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        ra_reg    <= ra_next;
        ca_reg    <= ca_next;
        rb_reg    <= rb_next;
        cb_reg    <= cb_next;
        rad_reg   <= rad_next;
        color_reg <= color_next;
        tot_reg   <= tot_next;
        step_reg  <= step_next;
        t2_reg    <= t2_next;
        d2r_reg   <= d2r_next;
        d2c_reg   <= d2c_next;
        qr_reg    <= qr_next;
        qc_reg    <= qc_next;
        remr_reg  <= remr_next;
        remc_reg  <= remc_next;
        rad2_reg  <= rad2_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ysq_reg   <= ysq_next;
        ph_reg    <= ph_next;
        pix_reg   <= pix_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pix_reg;

    // The root unit reports a result only while the circle waits on it.
    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == ST_CIR_SQRT))
        else $error("square root result outside circle step");

    // The root unit only runs while the circle waits on it.
    a_sqrt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.busy |-> (state_reg == ST_CIR_SQRT))
        else $error("square root busy outside circle step");

    // No pixel is written while a read is in flight.
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RD_ADDR) || (state_reg == ST_RD_OUT)) |-> !ram_we)
        else $error("pixel write during read");

    // Line remainders stay within one divisor.
    a_line_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LINE) && (tot_reg != '0)) |->
        ((remr_reg >= 0) && (remr_reg < $signed({2'b00, t2_reg}))
         && (remc_reg >= 0) && (remc_reg < $signed({2'b00, t2_reg}))))
        else $error("line remainder out of range");

    // A command is only taken in idle, so a sweep holds the input stalled.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("command taken during clear");

endmodule

// ----- test/testbench.sv -----
// Testbench for the framebuffer line and circle drawing engine.
`timescale 1ns / 100ps

module testbench;

    import fbd_pkg::*;

    localparam int FH = 64;
    localparam int FW = 128;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] mode;
    logic [9:0] row_a;
    logic [9:0] col_a;
    logic [9:0] row_b;
    logic [9:0] col_b;
    logic [9:0] radius;
    logic       color;
    logic       out_valid;
    logic       out_stall;
    logic       pixel_value;

    // Predicted pixel store and queue of predicted read values.
    bit         shadow_frame [FH*FW];
    bit         pending_pixels [$];
    int         mismatch_count;
    bit         idle_enable;
    bit         sink_idle_enable;

    framebuffer_line_circle_drawer_unit #(
        .FRAME_HEIGHT(FH),
        .FRAME_WIDTH(FW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .row_a(row_a),
        .col_a(col_a),
        .row_b(row_b),
        .col_b(col_b),
        .radius(radius),
        .color(color),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_value(pixel_value)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run time limit.
    initial
    begin
        #400ms;
        $display("Regression FAIL");
        $finish;
    end

    // Clipped write of one predicted pixel.
    function automatic void shadow_plot(longint r, longint c, bit v);
        if (r < 0 || c < 0 || r >= FH || c >= FW)
            return;
        shadow_frame[r*FW + c] = v;
    endfunction

    function automatic longint rounded_lerp(longint s0, longint d, longint k, longint tot);
        longint n;
        n = s0 * tot + d * k;
        return (2 * n + tot) / (2 * tot);
    endfunction

    function automatic int unsigned nearest_sqrt(int unsigned v);
        int unsigned s;
        s = 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        if (v > s * s + s)
            s++;
        return s;
    endfunction

    // Apply one command to the predicted store and queue any read value.
    function automatic void predict_command(logic [2:0] m, longint ra, longint ca,
                                            longint rb, longint cb, int unsigned rad,
                                            bit c);
        longint dr, dc, tot, x, y;
        case (m)
            MODE_CLEAR:
                foreach (shadow_frame[i]) shadow_frame[i] = 1'b0;
            MODE_POINT:
                shadow_plot(ra, ca, c);
            MODE_LINE:
            begin
                dr = rb - ra;
                dc = cb - ca;
                tot = (dr < 0 ? -dr : dr);
                if ((dc < 0 ? -dc : dc) > tot)
                    tot = (dc < 0 ? -dc : dc);
                if (tot == 0)
                    shadow_plot(ra, ca, 1'b1);
                else
                    for (longint k = 0; k <= tot; k++)
                        shadow_plot(rounded_lerp(ra, dr, k, tot),
                                    rounded_lerp(ca, dc, k, tot), 1'b1);
            end
            MODE_CIRCLE:
            begin
                x = rad;
                y = 0;
                while (y <= x)
                begin
                    x = nearest_sqrt(rad * rad - int'(y * y));
                    shadow_plot(ra + y, ca + x, 1'b1);
                    shadow_plot(ra - y, ca + x, 1'b1);
                    shadow_plot(ra + y, ca - x, 1'b1);
                    shadow_plot(ra - y, ca - x, 1'b1);
                    shadow_plot(ra + x, ca + y, 1'b1);
                    shadow_plot(ra - x, ca + y, 1'b1);
                    shadow_plot(ra + x, ca - y, 1'b1);
                    shadow_plot(ra - x, ca - y, 1'b1);
                    y++;
                end
            end
            MODE_READ:
                if (ra < FH && ca < FW)
                    pending_pixels.push_back(shadow_frame[ra*FW + ca]);
                else
                    pending_pixels.push_back(1'b0);
            default: ;
        endcase
    endfunction

    // Drop the command valid and scramble the idle mode, row_a and col_a.
    task automatic release_input();
        in_valid <= 1'b0;
        mode     <= 3'($urandom);
        row_a    <= 10'($urandom);
        col_a    <= 10'($urandom);
    endtask

    // Send one command beat, with an optional random gap before it.
    // The beat stays driven after acceptance until the next beat or a gap replaces it.
    task automatic send_command(logic [2:0] m, logic [9:0] ra, logic [9:0] ca,
                                logic [9:0] rb, logic [9:0] cb, logic [9:0] rad,
                                logic c);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            release_input();
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        row_a    <= ra;
        col_a    <= ca;
        row_b    <= rb;
        col_b    <= cb;
        radius   <= rad;
        color    <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_command(m, ra, ca, rb, cb, rad, c);
        @(negedge clk);
    endtask

    // Wait until every predicted read has come back.
    task automatic drain_reads();
        release_input();
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Coordinates mostly on the frame, sometimes anywhere.
    function automatic logic [9:0] pick_row();
        return ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, FH + 4));
    endfunction

    function automatic logic [9:0] pick_col();
        return ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, FW + 4));
    endfunction

    task automatic test_points_and_reads();
        send_command(MODE_READ, 0, 0, 0, 0, 0, 0);
        send_command(MODE_POINT, 0, 0, 0, 0, 0, 1);
        send_command(MODE_POINT, FH-1, FW-1, 0, 0, 0, 1);
        send_command(MODE_POINT, 1023, 1023, 1023, 1023, 1023, 1);
        send_command(MODE_READ, 0, 0, 0, 0, 0, 0);
        send_command(MODE_READ, FH-1, FW-1, 0, 0, 0, 0);
        send_command(MODE_READ, 1023, 1023, 0, 0, 0, 0);
        send_command(MODE_POINT, 0, 0, 0, 0, 0, 0);
        send_command(MODE_READ, 0, 0, 0, 0, 0, 0);
        send_command(3'd5, 3, 3, 0, 0, 0, 1);
        send_command(3'd7, 3, 3, 0, 0, 0, 1);
        send_command(MODE_READ, 3, 3, 0, 0, 0, 0);
    endtask

    task automatic test_lines_and_circles();
        send_command(MODE_LINE, 5, 5, 5, 5, 0, 0);
        send_command(MODE_READ, 5, 5, 0, 0, 0, 0);
        send_command(MODE_LINE, 0, 0, FH-1, FW-1, 0, 0);
        send_command(MODE_READ, 32, 64, 0, 0, 0, 0);
        send_command(MODE_LINE, 60, 2, 3, 120, 0, 0);
        send_command(MODE_CIRCLE, 30, 60, 0, 0, 0, 0);
        send_command(MODE_READ, 30, 60, 0, 0, 0, 0);
        send_command(MODE_CIRCLE, 32, 64, 0, 0, 20, 0);
        send_command(MODE_READ, 32, 84, 0, 0, 0, 0);
        send_command(MODE_CIRCLE, 0, 0, 0, 0, 5, 0);
        send_command(MODE_READ, 0, 5, 0, 0, 0, 0);
        send_command(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        send_command(MODE_READ, 32, 84, 0, 0, 0, 0);
    endtask

    // Random drawing with reads; the sender holds off once until all reads return.
    task automatic test_random_drawing(int count);
        logic [2:0] m;
        logic [9:0] rad;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_reads();
            case ($urandom_range(0, 19))
                0:          m = MODE_CLEAR;
                1, 2, 3:    m = MODE_POINT;
                4, 5, 6:    m = MODE_LINE;
                7, 8:       m = MODE_CIRCLE;
                9:          m = 3'($urandom_range(5, 7));
                default:    m = MODE_READ;
            endcase
            rad = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
            if (m == MODE_CIRCLE && rad > 100)
                send_command(m, 10'($urandom), 10'($urandom), 10'($urandom),
                             10'($urandom), rad, 1'($urandom));
            else
                send_command(m, pick_row(), pick_col(), pick_row(), pick_col(),
                             rad, 1'($urandom));
        end
    endtask

    // Result checker and random stall on the result side.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected read beat: pixel_value %0b", pixel_value);
                end
                else if (pixel_value !== pending_pixels[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel_value mismatch: expected %0b actual %0b",
                                 pending_pixels[0], pixel_value);
                    void'(pending_pixels.pop_front());
                end
                else
                    void'(pending_pixels.pop_front());
            end
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (sink_idle_enable && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            out_stall <= (stall_left > 0);
        end
    end

    // Main sequence.
    initial
    begin
        int waited;
        idle_enable = 1'b1;
        sink_idle_enable = 1'b1;
        mismatch_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        row_a = '0;
        col_a = '0;
        row_b = '0;
        col_b = '0;
        radius = '0;
        color = 1'b0;
        foreach (shadow_frame[i]) shadow_frame[i] = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_points_and_reads();
        test_lines_and_circles();
        test_random_drawing(220);
        idle_enable = 1'b0;
        sink_idle_enable = 1'b0;
        test_random_drawing(45);
        release_input();
        waited = 0;
        while (pending_pixels.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (50) @(negedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/fbd_pkg.sv
rtl/core/fbd_ram.sv
rtl/core/fbd_sqrt.sv
rtl/core/framebuffer_line_circle_drawer_unit.sv
test/testbench.sv
